// File: rtl/tbb_pkg.sv
package tbb_pkg;

  localparam int CoordW = 24;
  localparam int CoefW = 16;
  localparam int ProdW = 2 * CoefW;
  localparam int AccW = 34;
  localparam int RowW = 64;
  localparam int CfgIdxW = 2;
  localparam int AxisCount = 3;
  localparam int QueueDepthDefault = 4;

  localparam logic signed [CoordW-1:0] CoordMax = {1'b0, {(CoordW-1){1'b1}}};
  localparam logic signed [CoordW-1:0] CoordMin = {1'b1, {(CoordW-1){1'b0}}};

  localparam logic [RowW-1:0] RowXReset = 64'h0000_0000_0000_0100;
  localparam logic [RowW-1:0] RowYReset = 64'h0000_0000_0100_0000;
  localparam logic [RowW-1:0] RowZReset = 64'h0000_0100_0000_0000;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic [RowW-1:0] row_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ROW_X = 2'd0,
    CFG_ROW_Y = 2'd1,
    CFG_ROW_Z = 2'd2
  } cfg_index_t;

  typedef struct packed {
    coord_t t_x;
    coord_t t_y;
    coord_t t_z;
    logic   last;
  } point_entry_t;

  typedef struct packed {
    logic         valid;
    point_entry_t entry;
  } point_push_t;

  function automatic coord_t saturate_q16(input logic signed [AccW-1:0] acc);
    logic signed [AccW-1:0] shifted;
    coord_t result;
    shifted = acc >>> 8;
    if (shifted > AccW'(CoordMax)) begin
      result = CoordMax;
    end else if (shifted < AccW'(CoordMin)) begin
      result = CoordMin;
    end else begin
      result = shifted[CoordW-1:0];
    end
    return result;
  endfunction

endpackage

// File: rtl/transformed_bounding_box.sv
// Axis-aligned bounding box of vertices under an affine transform, one vertex per
// cycle sustained. A vertex passes a multiply stage and a sum-and-saturate stage,
// then waits in a small queue before the min/max stage, which registers a box
// when its final vertex leaves the queue and the output is free. The input
// stalls only when the queue plus the two transform stages hold QueueDepth
// vertices, which happens only while a finished box is held by a stalled output.
module transformed_bounding_box
  import tbb_pkg::*;
#(
  parameter int QueueDepth = QueueDepthDefault
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CfgIdxW-1:0]          cfg_index,
  input  logic [RowW-1:0]             cfg_data,
  input  logic                        vertex_valid,
  output logic                        vertex_stall,
  input  logic signed [CoefW-1:0]     pos_x,
  input  logic signed [CoefW-1:0]     pos_y,
  input  logic signed [CoefW-1:0]     pos_z,
  input  logic                        final_vertex,
  output logic                        box_valid,
  input  logic                        box_stall,
  output logic signed [CoordW-1:0]    low_x,
  output logic signed [CoordW-1:0]    low_y,
  output logic signed [CoordW-1:0]    low_z,
  output logic signed [CoordW-1:0]    high_x,
  output logic signed [CoordW-1:0]    high_y,
  output logic signed [CoordW-1:0]    high_z
);

  localparam int CountW = $clog2(QueueDepth + 1);
  localparam int CreditW = CountW + 2;

  row_t row_x, row_y, row_z;
  logic take;
  point_push_t push;
  logic [1:0] busy;
  logic pop;
  logic head_valid;
  point_entry_t head;
  logic [CountW-1:0] q_count;
  logic [CreditW-1:0] in_flight;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_x <= RowXReset;
      row_y <= RowYReset;
      row_z <= RowZReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ROW_X: row_x <= cfg_data;
        CFG_ROW_Y: row_y <= cfg_data;
        CFG_ROW_Z: row_z <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign in_flight = CreditW'(busy) + CreditW'(q_count);
  assign vertex_stall = (in_flight >= CreditW'(QueueDepth));
  assign take = vertex_valid && !vertex_stall;

  tbb_front u_front (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .final_vertex (final_vertex),
    .row_x        (row_x),
    .row_y        (row_y),
    .row_z        (row_z),
    .push         (push),
    .busy         (busy)
  );

  tbb_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head),
    .count      (q_count)
  );

  tbb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .box_valid  (box_valid),
    .box_stall  (box_stall),
    .low_x      (low_x),
    .low_y      (low_y),
    .low_z      (low_z),
    .high_x     (high_x),
    .high_y     (high_y),
    .high_z     (high_z)
  );

`ifndef SYNTHESIS
  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    in_flight <= CreditW'(QueueDepth))
    else $error("vertices in flight exceed queue depth");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> (q_count < CountW'(QueueDepth) || pop))
    else $error("queue written while full");

  a_box_from_final: assert property (@(posedge clk) disable iff (rst)
    $rose(box_valid) |-> $past(pop && head.last))
    else $error("box raised without a final vertex");

  a_box_drops: assert property (@(posedge clk) disable iff (rst)
    (box_valid && !box_stall && !(pop && head.last)) |=> !box_valid)
    else $error("box held after its transfer");
`endif

endmodule

// File: rtl/tbb_front.sv
module tbb_front
  import tbb_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     take,
  input  logic signed [CoefW-1:0]  pos_x,
  input  logic signed [CoefW-1:0]  pos_y,
  input  logic signed [CoefW-1:0]  pos_z,
  input  logic                     final_vertex,
  input  row_t                     row_x,
  input  row_t                     row_y,
  input  row_t                     row_z,
  output point_push_t              push,
  output logic [1:0]               busy
);

  row_t rows [AxisCount];
  logic signed [ProdW-1:0] prod [AxisCount][3];
  logic s1_valid;
  logic s1_last;
  logic signed [AccW-1:0] acc [AxisCount];
  coord_t sat [AxisCount];

  assign rows[0] = row_x;
  assign rows[1] = row_y;
  assign rows[2] = row_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_last <= final_vertex;
      for (int a = 0; a < AxisCount; a++) begin
        prod[a][0] <= $signed(rows[a][15:0]) * pos_x;
        prod[a][1] <= $signed(rows[a][31:16]) * pos_y;
        prod[a][2] <= $signed(rows[a][47:32]) * pos_z;
      end
    end
  end

  always_comb begin
    for (int a = 0; a < AxisCount; a++) begin
      acc[a] = AccW'(prod[a][0]) + AccW'(prod[a][1]) + AccW'(prod[a][2])
             + (AccW'($signed(rows[a][63:48])) <<< 8);
      sat[a] = saturate_q16(acc[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      push.valid <= 1'b0;
    end else begin
      push.valid <= s1_valid;
    end
    if (s1_valid) begin
      push.entry.t_x  <= sat[0];
      push.entry.t_y  <= sat[1];
      push.entry.t_z  <= sat[2];
      push.entry.last <= s1_last;
    end
  end

  assign busy = 2'(s1_valid) + 2'(push.valid);

endmodule

// File: rtl/tbb_queue.sv
module tbb_queue
  import tbb_pkg::*;
#(
  parameter int Depth = QueueDepthDefault
) (
  input  logic                         clk,
  input  logic                         rst,
  input  point_push_t                  push,
  input  logic                         pop,
  output logic                         head_valid,
  output point_entry_t                 head,
  output logic [$clog2(Depth+1)-1:0]   count
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CountW = $clog2(Depth + 1);

  point_entry_t slots [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] ptr);
    logic [PtrW-1:0] result;
    if (ptr == PtrW'(Depth - 1)) begin
      result = '0;
    end else begin
      result = ptr + 1'b1;
    end
    return result;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      count <= count + CountW'(push.valid) - CountW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      slots[wr_ptr] <= push.entry;
    end
  end

  assign head_valid = (count != '0);
  assign head = slots[rd_ptr];

endmodule

// File: rtl/tbb_back.sv
module tbb_back
  import tbb_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  point_entry_t  head,
  output logic          pop,
  output logic          box_valid,
  input  logic          box_stall,
  output coord_t        low_x,
  output coord_t        low_y,
  output coord_t        low_z,
  output coord_t        high_x,
  output coord_t        high_y,
  output coord_t        high_z
);

  coord_t run_low_x, run_low_y, run_low_z;
  coord_t run_high_x, run_high_y, run_high_z;
  coord_t low_x_next, low_y_next, low_z_next;
  coord_t high_x_next, high_y_next, high_z_next;

  assign pop = head_valid && (!head.last || !box_valid || !box_stall);

  always_comb begin
    low_x_next  = (head.t_x < run_low_x)  ? head.t_x : run_low_x;
    low_y_next  = (head.t_y < run_low_y)  ? head.t_y : run_low_y;
    low_z_next  = (head.t_z < run_low_z)  ? head.t_z : run_low_z;
    high_x_next = (head.t_x > run_high_x) ? head.t_x : run_high_x;
    high_y_next = (head.t_y > run_high_y) ? head.t_y : run_high_y;
    high_z_next = (head.t_z > run_high_z) ? head.t_z : run_high_z;
  end

  always_ff @(posedge clk) begin
    if (rst || (pop && head.last)) begin
      run_low_x  <= CoordMax;
      run_low_y  <= CoordMax;
      run_low_z  <= CoordMax;
      run_high_x <= CoordMin;
      run_high_y <= CoordMin;
      run_high_z <= CoordMin;
    end else if (pop) begin
      run_low_x  <= low_x_next;
      run_low_y  <= low_y_next;
      run_low_z  <= low_z_next;
      run_high_x <= high_x_next;
      run_high_y <= high_y_next;
      run_high_z <= high_z_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      box_valid <= 1'b0;
    end else if (pop && head.last) begin
      box_valid <= 1'b1;
    end else if (!box_stall) begin
      box_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last) begin
      low_x  <= low_x_next;
      low_y  <= low_y_next;
      low_z  <= low_z_next;
      high_x <= high_x_next;
      high_y <= high_y_next;
      high_z <= high_z_next;
    end
  end

endmodule

// File: tb/transformed_bounding_box_test.sv
module transformed_bounding_box_test;
  import tbb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CfgIdxW-1:0] CfgIndexUnused = 2'd3;
  localparam int SettleCycles = 8;
  localparam int ChokeCycles = 120;

  class box_scoreboard;
    typedef struct packed {
      coord_t low_x;
      coord_t low_y;
      coord_t low_z;
      coord_t high_x;
      coord_t high_y;
      coord_t high_z;
    } box_t;

    row_t rows[AxisCount];
    int run_low[AxisCount];
    int run_high[AxisCount];
    box_t boxes[$];
    int errors;

    function new();
      rows[0] = RowXReset;
      rows[1] = RowYReset;
      rows[2] = RowZReset;
      errors = 0;
      clear_running();
    endfunction

    function void clear_running();
      for (int a = 0; a < AxisCount; a++) begin
        run_low[a] = int'(CoordMax);
        run_high[a] = int'(CoordMin);
      end
    endfunction

    function void write_row(logic [CfgIdxW-1:0] index, row_t data);
      if (index <= CFG_ROW_Z) rows[index] = data;
    endfunction

    function int transform(row_t row, int x, int y, int z);
      longint acc;
      acc = longint'($signed(row[15:0])) * x + longint'($signed(row[31:16])) * y
          + longint'($signed(row[47:32])) * z + longint'($signed(row[63:48])) * 256;
      acc = acc >>> 8;
      if (acc > longint'(CoordMax)) acc = longint'(CoordMax);
      if (acc < longint'(CoordMin)) acc = longint'(CoordMin);
      return int'(acc);
    endfunction

    function void note_vertex(logic signed [CoefW-1:0] x, logic signed [CoefW-1:0] y,
                              logic signed [CoefW-1:0] z, logic last);
      int t;
      box_t box;
      for (int a = 0; a < AxisCount; a++) begin
        t = transform(rows[a], x, y, z);
        if (t < run_low[a]) run_low[a] = t;
        if (t > run_high[a]) run_high[a] = t;
      end
      if (last) begin
        box.low_x = coord_t'(run_low[0]);
        box.low_y = coord_t'(run_low[1]);
        box.low_z = coord_t'(run_low[2]);
        box.high_x = coord_t'(run_high[0]);
        box.high_y = coord_t'(run_high[1]);
        box.high_z = coord_t'(run_high[2]);
        boxes.insert(boxes.size(), box);
        clear_running();
      end
    endfunction

    function void compare_field(string name, coord_t want, coord_t got);
      if (want !== got) begin
        $error("%s expected %0d got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_box(coord_t lx, coord_t ly, coord_t lz,
                            coord_t hx, coord_t hy, coord_t hz);
      box_t want;
      if (boxes.size() == 0) begin
        $error("box transfer with no box expected");
        errors++;
        return;
      end
      want = boxes.pop_front();
      compare_field("low_x", want.low_x, lx);
      compare_field("low_y", want.low_y, ly);
      compare_field("low_z", want.low_z, lz);
      compare_field("high_x", want.high_x, hx);
      compare_field("high_y", want.high_y, hy);
      compare_field("high_z", want.high_z, hz);
    endfunction

    function int pending();
      return boxes.size();
    endfunction

    function void check_drained();
      if (boxes.size() != 0) begin
        $error("%0d boxes never arrived", boxes.size());
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [RowW-1:0] cfg_data;
  logic vertex_valid;
  logic vertex_stall;
  logic signed [CoefW-1:0] pos_x;
  logic signed [CoefW-1:0] pos_y;
  logic signed [CoefW-1:0] pos_z;
  logic final_vertex;
  logic box_valid;
  logic box_stall;
  coord_t low_x, low_y, low_z;
  coord_t high_x, high_y, high_z;

  logic quiet;
  logic choke;
  logic choke_done;

  box_scoreboard sb = new();

  transformed_bounding_box dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .vertex_valid(vertex_valid),
    .vertex_stall(vertex_stall),
    .pos_x(pos_x),
    .pos_y(pos_y),
    .pos_z(pos_z),
    .final_vertex(final_vertex),
    .box_valid(box_valid),
    .box_stall(box_stall),
    .low_x(low_x),
    .low_y(low_y),
    .low_z(low_z),
    .high_x(high_x),
    .high_y(high_y),
    .high_z(high_z)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("simulation failed");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && box_valid && !box_stall) begin
      sb.check_box(low_x, low_y, low_z, high_x, high_y, high_z);
    end
  end

  // The long hold lets finished boxes back up until the vertex input stalls.
  initial begin
    box_stall = 1'b0;
    choke_done = 1'b0;
    forever begin
      @(negedge clk);
      if (choke && !choke_done) begin
        box_stall = 1'b1;
        repeat (ChokeCycles) @(negedge clk);
        choke_done = 1'b1;
        box_stall = 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        box_stall = 1'b1;
        repeat ($urandom_range(1, 4)) @(negedge clk);
        box_stall = 1'b0;
      end
    end
  end

  task automatic send_vertex(logic signed [CoefW-1:0] x, logic signed [CoefW-1:0] y,
                             logic signed [CoefW-1:0] z, logic last);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      vertex_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    vertex_valid = 1'b1;
    pos_x = x;
    pos_y = y;
    pos_z = z;
    final_vertex = last;
    do @(posedge clk); while (vertex_stall);
    sb.note_vertex(x, y, z, last);
    @(negedge clk);
  endtask

  task automatic write_row(logic [CfgIdxW-1:0] index, row_t data);
    cfg_valid = 1'b1;
    cfg_index = index;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_row(index, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_idle();
    vertex_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic signed [CoefW-1:0] random_coord();
    if ($urandom_range(0, 3) == 0) return CoefW'(int'($urandom_range(0, 2048)) - 1024);
    return CoefW'($urandom);
  endfunction

  function automatic row_t random_row(bit tame);
    row_t row;
    for (int f = 0; f < 4; f++) begin
      if (tame) row[f*CoefW +: CoefW] = CoefW'(int'($urandom_range(0, 1024)) - 512);
      else row[f*CoefW +: CoefW] = CoefW'($urandom);
    end
    return row;
  endfunction

  task automatic load_rows(bit tame);
    write_row(CFG_ROW_X, random_row(tame));
    write_row(CFG_ROW_Y, random_row(tame));
    write_row(CFG_ROW_Z, random_row(tame));
  endtask

  task automatic random_phase(int items, int longest);
    int sent;
    int count;
    sent = 0;
    while (sent < items) begin
      count = $urandom_range(1, longest);
      for (int i = 0; i < count; i++) begin
        send_vertex(random_coord(), random_coord(), random_coord(), i == count - 1);
      end
      sent += count;
    end
    wait_idle();
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = CFG_ROW_X;
    cfg_data = '0;
    vertex_valid = 1'b0;
    pos_x = '0;
    pos_y = '0;
    pos_z = '0;
    final_vertex = 1'b0;
    quiet = 1'b0;
    choke = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Identity transform out of reset, single-vertex sets, ignored index.
    send_vertex(16'sh7FFF, -16'sh8000, 16'sh0000, 1'b0);
    send_vertex(-16'sh8000, 16'sh7FFF, -16'sh0001, 1'b1);
    send_vertex(16'sh0000, 16'sh0000, 16'sh0000, 1'b1);
    send_vertex(-16'sh0001, 16'sh0001, 16'sh5555, 1'b1);
    wait_idle();
    write_row(CfgIndexUnused, '1);
    send_vertex(16'sh0100, -16'sh0100, 16'sh2AAA, 1'b1);
    wait_idle();

    // Extreme coefficients drive the x and y axes into saturation; the z row is zero.
    write_row(CFG_ROW_X, 64'h7FFF_7FFF_7FFF_7FFF);
    write_row(CFG_ROW_Y, 64'h8000_8000_8000_8000);
    write_row(CFG_ROW_Z, 64'h0000_0000_0000_0000);
    send_vertex(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0);
    send_vertex(-16'sh8000, -16'sh8000, -16'sh8000, 1'b0);
    send_vertex(16'sh0000, 16'sh0000, 16'sh0000, 1'b1);
    send_vertex(16'sh7FFF, -16'sh8000, 16'sh0001, 1'b1);
    wait_idle();

    // Negative unit coefficients, sub-unit scale that rounds down, pure offset.
    write_row(CFG_ROW_X, 64'hFFFF_FFFF_FFFF_FFFF);
    write_row(CFG_ROW_Y, 64'h0000_0000_0000_0001);
    write_row(CFG_ROW_Z, 64'h0100_0000_0000_0000);
    send_vertex(-16'sh0001, 16'sh0001, -16'sh00FF, 1'b0);
    send_vertex(16'sh0001, -16'sh0001, 16'sh00FF, 1'b1);
    send_vertex(-16'sh8000, 16'sh7FFF, -16'sh8000, 1'b1);
    wait_idle();

    load_rows(1'b0);
    random_phase(100, 8);

    load_rows(1'b1);
    choke = 1'b1;
    random_phase(100, 3);

    write_row(CFG_ROW_X, random_row(1'b0));
    write_row(CFG_ROW_Y, random_row(1'b1));
    write_row(CFG_ROW_Z, RowZReset);
    random_phase(100, 16);

    quiet = 1'b1;
    load_rows(1'b0);
    random_phase(100, 6);

    sb.check_drained();
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: transformed_bounding_box.f
rtl/tbb_pkg.sv
rtl/tbb_front.sv
rtl/tbb_queue.sv
rtl/tbb_back.sv
rtl/transformed_bounding_box.sv
tb/transformed_bounding_box_test.sv
